/* design/next_permutation_generator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the next permutation generator
// Short forms for clocked implication checks with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef NEXT_PERMUTATION_GENERATOR_TOP_MACROS_SVH
`define NEXT_PERMUTATION_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define NPG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define NPG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/npg_pkg.sv */
// ----------------------------------------------------------------------------
// npg_pkg
// Shared types and constants of the next permutation generator.
// ----------------------------------------------------------------------------
`default_nettype none

package npg_pkg;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned RS_W   = 3;
  localparam int unsigned RE_W   = 4;
  localparam int unsigned CFG_W  = 4;

  localparam logic [ELEM_W-1:0] RESERVED_VAL = 16'hFFFF;
  localparam logic [ELEM_W-1:0] SAT_VAL      = 16'hFFFE;

  localparam logic REG_RANGE_START = 1'b0;
  localparam logic REG_RANGE_END   = 1'b1;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_SEARCH,
    ST_SWAP,
    ST_SORT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ELEM_W-1:0] wd;
    logic              pair_l;
    logic              pair_r;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* design/next_permutation_generator_top.sv */
// ----------------------------------------------------------------------------
// next_permutation_generator_top
// Lexicographic next-permutation stepper over a row of element cells.
// ----------------------------------------------------------------------------
// A write item stores one element. An advance item walks the pivot from
// the right (one position a cycle), scans the suffix for the smallest
// larger element (one position a cycle), swaps, then runs NUM_ELEMENTS
// odd-even compare-exchange passes across the suffix, and finally emits
// NUM_ELEMENTS items, one a cycle while the output is not stalled. Without
// a pivot in the window it emits the row unchanged. Pivot walk, scan and
// emission all go through the single shared read port.
`default_nettype none
`include "next_permutation_generator_top_macros.svh"

module next_permutation_generator_top #(
  parameter int unsigned NUM_ELEMENTS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_addr_i,
  input  wire  [3:0]  cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // index[2:0], value[18:3], zero pad
  input  wire         s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // position[2:0], element[18:3], zero pad
  output logic        m_axis_tuser,   // advanced
  output logic        m_axis_tlast
);

  localparam int unsigned N  = NUM_ELEMENTS;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned HW = $clog2(N + 1);
  localparam int unsigned EW = npg_pkg::ELEM_W;

  npg_pkg::state_e state_q, state_d;

  logic [npg_pkg::RS_W-1:0] rs_q;
  logic [npg_pkg::RE_W-1:0] re_q;

  logic [IW-1:0] q_q, q_d, j_q, j_d, k_q, k_d, bi_q, bi_d;
  logic [HW-1:0] hi_q, hi_d, pass_q, pass_d;
  logic [npg_pkg::RS_W-1:0] lo_q, lo_d;
  logic [EW-1:0] cur_q, cur_d, best_q, best_d;
  logic          found_q, found_d, adv_q, adv_d;

  logic          ov_q, ov_d, olast_q, olast_d, oadv_q, oadv_d;
  logic [npg_pkg::POS_W-1:0] opos_q, opos_d;
  logic [EW-1:0] oelem_q, oelem_d;

  logic [EW-1:0] elem [N];
  logic [N-1:0]  lt;
  npg_pkg::cell_ctrl_t ctrl [N];
  logic [N-1:0]  pair_act;

  logic [IW-1:0] rd_idx;
  logic [EW-1:0] rd_val;
  logic          in_acc, wr_en, swap_en;
  logic [2:0]    in_idx;
  logic [EW-1:0] in_val;
  logic [IW+2:0] kx;
  logic [HW-1:0] hi_c;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_idx  = s_axis_tdata[2:0];
  assign in_val  = (s_axis_tdata[18:3] == npg_pkg::RESERVED_VAL) ? npg_pkg::SAT_VAL
                                                                  : s_axis_tdata[18:3];
  assign wr_en   = in_acc && (s_axis_tuser == npg_pkg::OP_WRITE) && (32'(in_idx) < N);
  assign swap_en = (state_q == npg_pkg::ST_SWAP);
  assign hi_c    = (32'(re_q) > N) ? HW'(N) : HW'(re_q);
  assign rd_val  = elem[rd_idx];
  assign kx      = {3'b000, k_q};

  // cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      pair_act[i] = (state_q == npg_pkg::ST_SORT) && ((i % 2) == int'(pass_q[0]))
                    && (i >= int'(q_q) + 1) && (i + 1 < int'(hi_q));
      ctrl[i].we     = (wr_en && (32'(in_idx) == i))
                       || (swap_en && ((32'(q_q) == i) || (32'(bi_q) == i)));
      ctrl[i].wd     = wr_en ? in_val : ((32'(q_q) == i) ? best_q : cur_q);
      ctrl[i].pair_r = pair_act[i];
      ctrl[i].pair_l = (i > 0) ? pair_act[(i > 0) ? i - 1 : 0] : 1'b0;
    end
    npg_cell #(.RESET_VAL(16'(i))) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[i]),
      .left_i  ((i > 0) ? elem[(i > 0) ? i - 1 : 0] : '0),
      .right_i ((i < N - 1) ? elem[(i < N - 1) ? i + 1 : i] : '0),
      .elem_o  (elem[i]),
      .lt_o    (lt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= '0;
      re_q <= 4'd8;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == npg_pkg::REG_RANGE_START) begin
        rs_q <= cfg_wdata_i[npg_pkg::RS_W-1:0];
      end else begin
        re_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    q_d = q_q; j_d = j_q; k_d = k_q; bi_d = bi_q;
    hi_d = hi_q; lo_d = lo_q; pass_d = pass_q;
    cur_d = cur_q; best_d = best_q; found_d = found_q; adv_d = adv_q;
    ov_d = ov_q && !m_axis_tready;
    olast_d = olast_q; oadv_d = oadv_q; opos_d = opos_q; oelem_d = oelem_q;
    rd_idx = k_q;
    s_axis_tready = (state_q == npg_pkg::ST_IDLE);
    unique case (state_q)
      npg_pkg::ST_IDLE: begin
        if (in_acc && (s_axis_tuser == npg_pkg::OP_ADVANCE)) begin
          hi_d = hi_c;
          lo_d = rs_q;
          k_d  = '0;
          if ((32'(rs_q) >= 32'(hi_c)) || (32'(hi_c) - 32'(rs_q) < 2)) begin
            adv_d   = 1'b0;
            state_d = npg_pkg::ST_EMIT;
          end else begin
            q_d     = IW'(32'(hi_c) - 2);
            state_d = npg_pkg::ST_PIVOT;
          end
        end
      end
      npg_pkg::ST_PIVOT: begin
        rd_idx = q_q;
        if (lt[q_q]) begin
          cur_d   = rd_val;
          j_d     = q_q + IW'(1);
          found_d = 1'b0;
          state_d = npg_pkg::ST_SEARCH;
        end else if (32'(q_q) == 32'(lo_q)) begin
          adv_d   = 1'b0;
          state_d = npg_pkg::ST_EMIT;
        end else begin
          q_d = q_q - IW'(1);
        end
      end
      npg_pkg::ST_SEARCH: begin
        rd_idx = j_q;
        if ((rd_val > cur_q) && (!found_q || (rd_val < best_q))) begin
          found_d = 1'b1;
          best_d  = rd_val;
          bi_d    = j_q;
        end
        if (32'(j_q) + 1 == 32'(hi_q)) begin
          state_d = npg_pkg::ST_SWAP;
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      npg_pkg::ST_SWAP: begin
        pass_d  = '0;
        state_d = npg_pkg::ST_SORT;
      end
      npg_pkg::ST_SORT: begin
        if (32'(pass_q) == N - 1) begin
          adv_d   = 1'b1;
          state_d = npg_pkg::ST_EMIT;
        end else begin
          pass_d = pass_q + HW'(1);
        end
      end
      npg_pkg::ST_EMIT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          opos_d  = kx[2:0];
          oelem_d = rd_val;
          oadv_d  = adv_q;
          olast_d = (32'(k_q) == N - 1);
          if (32'(k_q) == N - 1) begin
            state_d = npg_pkg::ST_IDLE;
          end else begin
            k_d = k_q + IW'(1);
          end
        end
      end
      default: state_d = npg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npg_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; j_q <= j_d; k_q <= k_d; bi_q <= bi_d;
    hi_q <= hi_d; lo_q <= lo_d; pass_q <= pass_d;
    cur_q <= cur_d; best_q <= best_d; found_q <= found_d; adv_q <= adv_d;
    olast_q <= olast_d; oadv_q <= oadv_d; opos_q <= opos_d; oelem_q <= oelem_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {5'b0, oelem_q, opos_q};
  assign m_axis_tuser  = oadv_q;
  assign m_axis_tlast  = olast_q;

  `NPG_ASSERT_NXT(a_adv_leaves_idle, in_acc && (s_axis_tuser == npg_pkg::OP_ADVANCE),
                  state_q != npg_pkg::ST_IDLE)
  `NPG_ASSERT_NXT(a_swap_then_sort, state_q == npg_pkg::ST_SWAP,
                  state_q == npg_pkg::ST_SORT)
  `NPG_ASSERT_IMP(a_busy_not_ready, state_q != npg_pkg::ST_IDLE, !s_axis_tready)
  `NPG_ASSERT_IMP(a_sort_emit_adv, state_q == npg_pkg::ST_SORT && 32'(pass_q) == N - 1,
                  state_d == npg_pkg::ST_EMIT && adv_d)

endmodule

`default_nettype wire

/* design/npg_cell.sv */
// ----------------------------------------------------------------------------
// npg_cell
// One element slot: direct write or compare-exchange with a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module npg_cell #(
  parameter logic [15:0] RESET_VAL = 16'd0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  npg_pkg::cell_ctrl_t          ctrl_i,
  input  wire  [npg_pkg::ELEM_W-1:0]   left_i,
  input  wire  [npg_pkg::ELEM_W-1:0]   right_i,
  output logic [npg_pkg::ELEM_W-1:0]   elem_o,
  output logic                         lt_o
);

  logic [npg_pkg::ELEM_W-1:0] elem_q, elem_d;

  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.we) begin
      elem_d = ctrl_i.wd;
    end else if (ctrl_i.pair_r && (elem_q > right_i)) begin
      elem_d = right_i;
    end else if (ctrl_i.pair_l && (left_i > elem_q)) begin
      elem_d = left_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= RESET_VAL;
    end else begin
      elem_q <= elem_d;
    end
  end

  assign elem_o = elem_q;
  assign lt_o   = elem_q < right_i;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the next permutation generator: writes elements,
// steps permutations over several windows and checks every emitted item
// against an in-bench model of the stepping, under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned NE = 8;

  typedef struct packed {
    logic                       op;
    logic [2:0]                 idx;
    logic [npg_pkg::ELEM_W-1:0] val;
  } req_t;

  typedef struct packed {
    logic [2:0]                 pos;
    logic [npg_pkg::ELEM_W-1:0] elem;
    logic                       adv;
    logic                       last;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = npg_pkg::REG_RANGE_START;
  logic [3:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [23:0] m_axis_tdata;
  wire         m_axis_tuser;
  wire         m_axis_tlast;

  next_permutation_generator_top #(.NUM_ELEMENTS(NE)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  req_t                       pending_q[$];
  row_t                       rows_q[$];
  logic [npg_pkg::ELEM_W-1:0] arr[NE];
  int unsigned                win_lo, win_hi;
  int                         errors = 0;
  bit                         quiet = 1'b0;
  bit                         hold = 1'b0;

  // advance the permutation window of arr, returns 1 if it moved
  function automatic bit step_perm();
    int unsigned hi, q, i, j, bi;
    logic [npg_pkg::ELEM_W-1:0] cur, best, key;
    bit found;
    hi = (win_hi > NE) ? NE : win_hi;
    if (win_lo >= hi || hi - win_lo < 2) return 1'b0;
    for (q = hi - 1; q > win_lo; q--) begin
      cur = arr[q-1];
      found = 1'b0;
      best = '0;
      bi = 0;
      for (i = q; i < hi; i++)
        if (arr[i] > cur && (!found || arr[i] < best)) begin
          found = 1'b1; best = arr[i]; bi = i;
        end
      if (found) begin
        arr[bi] = cur;
        arr[q-1] = best;
        for (i = q + 1; i < hi; i++) begin
          key = arr[i];
          j = i;
          while (j > q && arr[j-1] > key) begin
            arr[j] = arr[j-1];
            j--;
          end
          arr[j] = key;
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_item(req_t r);
    bit moved;
    row_t row;
    if (r.op == npg_pkg::OP_WRITE) begin
      arr[r.idx] = (r.val == npg_pkg::RESERVED_VAL) ? npg_pkg::SAT_VAL : r.val;
      return;
    end
    moved = step_perm();
    for (int i = 0; i < NE; i++) begin
      row.pos = i[2:0];
      row.elem = arr[i];
      row.adv = moved;
      row.last = (i == NE - 1);
      rows_q.push_back(row);
    end
  endfunction

  function automatic bit gap();
    return !quiet && ($urandom_range(99) < 32);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item('{s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[18:3]});
        void'(pending_q.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready)) begin
        if (pending_q.size() != 0 && !hold && !gap()) begin
          req_t n;
          n = pending_q[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= n.op;
          s_axis_tdata <= {5'b0, n.val, n.idx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rows_q.size() == 0) begin
          $error("unexpected item: data %h", m_axis_tdata);
          errors++;
        end else begin
          row_t e;
          e = rows_q.pop_front();
          if (m_axis_tdata[2:0] !== e.pos) begin
            $error("position: expected %0d got %0d", e.pos, m_axis_tdata[2:0]);
            errors++;
          end
          if (m_axis_tdata[18:3] !== e.elem) begin
            $error("element: expected %0d got %0d", e.elem, m_axis_tdata[18:3]);
            errors++;
          end
          if (m_axis_tdata[23:19] !== 5'b0) begin
            $error("pad: expected 0 got %h", m_axis_tdata[23:19]);
            errors++;
          end
          if (m_axis_tuser !== e.adv) begin
            $error("advanced: expected %0d got %0d", e.adv, m_axis_tuser);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last: expected %0d got %0d", e.last, m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= !gap();
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || s_axis_tvalid || rows_q.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_reg(logic a, logic [3:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= a;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (a == npg_pkg::REG_RANGE_START) win_lo = d[2:0];
    else win_hi = d;
  endtask

  function automatic void add(logic op, logic [2:0] i, logic [npg_pkg::ELEM_W-1:0] v);
    pending_q.push_back('{op, i, v});
  endfunction

  task automatic rand_items(int n, int dup_range);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 65) begin
        add(npg_pkg::OP_ADVANCE, 3'($urandom), 16'($urandom));
      end else begin
        add(npg_pkg::OP_WRITE, 3'($urandom),
            (dup_range != 0) ? 16'($urandom_range(dup_range)) : 16'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NE; i++) arr[i] = 16'(i);
    win_lo = 0;
    win_hi = 8;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, reserved value, full window, last permutation, duplicates
    add(npg_pkg::OP_ADVANCE, 3'd0, 16'd0);
    add(npg_pkg::OP_WRITE, 3'd7, 16'hFFFF);
    add(npg_pkg::OP_WRITE, 3'd0, 16'hFFFE);
    add(npg_pkg::OP_WRITE, 3'd1, 16'd0);
    add(npg_pkg::OP_ADVANCE, 3'd7, 16'hFFFF);
    for (int i = 0; i < NE; i++) add(npg_pkg::OP_WRITE, i[2:0], 16'(NE - 1 - i));
    add(npg_pkg::OP_ADVANCE, 3'd0, 16'd0);
    add(npg_pkg::OP_WRITE, 3'd2, 16'd5);
    add(npg_pkg::OP_WRITE, 3'd3, 16'd5);
    add(npg_pkg::OP_ADVANCE, 3'd0, 16'd0);
    add(npg_pkg::OP_ADVANCE, 3'd0, 16'd0);
    drain();

    // window sweep, including empty, short and end past array
    set_reg(npg_pkg::REG_RANGE_START, 4'd5);
    set_reg(npg_pkg::REG_RANGE_END, 4'd15);
    add(npg_pkg::OP_ADVANCE, 3'd0, 16'd0);
    add(npg_pkg::OP_ADVANCE, 3'd0, 16'd0);
    drain();
    set_reg(npg_pkg::REG_RANGE_START, 4'd7);
    set_reg(npg_pkg::REG_RANGE_END, 4'd0);
    add(npg_pkg::OP_ADVANCE, 3'd0, 16'd0);
    drain();
    set_reg(npg_pkg::REG_RANGE_START, 4'd3);
    set_reg(npg_pkg::REG_RANGE_END, 4'd4);
    add(npg_pkg::OP_ADVANCE, 3'd0, 16'd0);
    drain();

    // pause sender until all items are queued
    hold = 1'b1;
    set_reg(npg_pkg::REG_RANGE_START, 4'd0);
    set_reg(npg_pkg::REG_RANGE_END, 4'd8);
    rand_items(30, 0);
    repeat (5) @(posedge clk_i);
    hold = 1'b0;
    drain();

    // random phases over several windows
    for (int ph = 0; ph < 6; ph++) begin
      set_reg(npg_pkg::REG_RANGE_START, 4'($urandom_range(7)));
      set_reg(npg_pkg::REG_RANGE_END, (ph == 0) ? 4'd8 : 4'($urandom_range(15)));
      quiet = (ph == 2);
      rand_items(56, (ph % 2) ? 3 : 0);
      drain();
    end
    quiet = 1'b0;
    set_reg(npg_pkg::REG_RANGE_START, 4'd0);
    set_reg(npg_pkg::REG_RANGE_END, 4'd3);
    rand_items(20, 2);
    drain();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
